[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
// needs a clock and an active-high reset name at each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while in reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// condition that must never hold, off while in reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

[rtl/ttps_pkg.sv]
// types and constants of the transposition table probe store
// no dependencies
`timescale 1ns / 1ps

package ttps_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int IDX_BITS    = $clog2(TABLE_SLOTS);
   localparam int COORD_BITS  = 5;
   localparam int SCORE_BITS  = 32;
   localparam int DEPTH_BITS  = 6;
   localparam int HASH_BITS   = 64;

   // item operation codes
   typedef enum logic {
      OP_PROBE = 1'b0,
      OP_STORE = 1'b1
   } op_type;

   // bound flag kept with each entry
   typedef enum logic [1:0] {
      FLAG_EXACT = 2'd0,
      FLAG_LOWER = 2'd1,
      FLAG_UPPER = 2'd2
   } flag_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0]        depth;
      logic signed [SCORE_BITS-1:0] score;
      flag_type                     flag;
      logic                         move_stored;
      logic [COORD_BITS-1:0]        row;
      logic [COORD_BITS-1:0]        col;
   } info_type;

   typedef struct packed {
      logic                 valid;
      logic [HASH_BITS-1:0] tag;
      info_type             info;
   } slot_type;

endpackage

[rtl/transposition_table_probe_store.sv]
// top level of the transposition table probe store
// depends on ttps_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  operation, hash, depth, window, value, move
//  rsp_      out        rsp_valid / rsp_ready  hit, cutoff, scores, best move, written
//
//  the slot memory is read at the accepting edge; the compare and write-back follow in the
//  compare stage, whose outcome is registered in the result register that drives rsp_valid
//  with rsp_ready high and no clearing pass running a beat enters each cycle
//  a store followed by an access to the same slot is served by forwarding the write data
//  after reset a clearing pass writes every one of the TABLE_SLOTS (1024) slots with req_ready low
//  rsp_ready low holds the result register; with the compare stage also full req_ready drops

module transposition_table_probe_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [ttps_pkg::HASH_BITS-1:0]        req_hash,
   input  logic [ttps_pkg::DEPTH_BITS-1:0]       req_remaining_depth,
   input  logic signed [ttps_pkg::SCORE_BITS-1:0] req_alpha,
   input  logic signed [ttps_pkg::SCORE_BITS-1:0] req_beta,
   input  logic signed [ttps_pkg::SCORE_BITS-1:0] req_value,
   input  logic                                  req_move_valid,
   input  logic [ttps_pkg::COORD_BITS-1:0]       req_move_row,
   input  logic [ttps_pkg::COORD_BITS-1:0]       req_move_col,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic                                  rsp_cutoff,
   output logic signed [ttps_pkg::SCORE_BITS-1:0] rsp_cutoff_value,
   output logic signed [ttps_pkg::SCORE_BITS-1:0] rsp_new_alpha,
   output logic signed [ttps_pkg::SCORE_BITS-1:0] rsp_new_beta,
   output logic                                  rsp_pv_valid,
   output logic [ttps_pkg::COORD_BITS-1:0]       rsp_pv_row,
   output logic [ttps_pkg::COORD_BITS-1:0]       rsp_pv_col,
   output logic                                  rsp_written
);
   import ttps_pkg::*;

   // slot memory and its read register
   slot_type slot_mem [TABLE_SLOTS];
   slot_type mem_rd_ff;

   // clearing pass state
   logic                clr_ff, clr_in;
   logic [IDX_BITS-1:0] clr_idx_ff, clr_idx_in;

   // compare stage
   logic                         s1_valid_ff, s1_valid_in;
   op_type                       s1_op_ff;
   logic [HASH_BITS-1:0]         s1_hash_ff;
   logic [DEPTH_BITS-1:0]        s1_depth_ff;
   logic signed [SCORE_BITS-1:0] s1_alpha_ff, s1_beta_ff, s1_value_ff;
   logic                         s1_mv_ff;
   logic [COORD_BITS-1:0]        s1_row_ff, s1_col_ff;

   // forwarding of the last write
   logic     fwd_ff, fwd_in;
   slot_type fwd_data_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_cutoff_ff, rsp_pv_valid_ff, rsp_written_ff;
   logic signed [SCORE_BITS-1:0] rsp_cv_ff, rsp_na_ff, rsp_nb_ff;
   logic [COORD_BITS-1:0]        rsp_row_ff, rsp_col_ff;

   // combinational
   logic                         req_accept, s1_adv, s1_move;
   slot_type                     entry, wr_data;
   logic                         match, deep, replace, s1_wr;
   logic signed [SCORE_BITS-1:0] e_score, na, nb, cv;
   logic                         cut;
   flag_type                     new_flag;
   logic                         mem_we;
   logic [IDX_BITS-1:0]          mem_wa;
   slot_type                     mem_wd;

   // handshake
   assign s1_adv     = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && s1_adv;
   assign req_ready  = !clr_ff && (!s1_valid_ff || s1_adv);
   assign req_accept = req_valid && req_ready;

   // entry seen by the compare stage
   assign entry   = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign e_score = entry.info.score;
   assign match   = entry.valid && (entry.tag == s1_hash_ff);
   assign deep    = entry.info.depth >= s1_depth_ff;
   assign replace = !match || (s1_depth_ff >= entry.info.depth);
   assign s1_wr   = s1_move && (s1_op_ff == OP_STORE) && replace;

   // probe evaluation
   always_comb begin
      na  = s1_alpha_ff;
      nb  = s1_beta_ff;
      cut = 1'b0;
      cv  = '0;
      if (match && deep) begin
         if (entry.info.flag == FLAG_EXACT) begin
            cut = 1'b1;
            cv  = e_score;
         end else begin
            if (entry.info.flag == FLAG_LOWER && e_score > na) begin
               na = e_score;
            end else if (entry.info.flag == FLAG_UPPER && e_score < nb) begin
               nb = e_score;
            end
            if (na >= nb) begin
               cut = 1'b1;
               cv  = e_score;
            end
         end
      end
   end

   // bound flag and entry for a store
   always_comb begin
      if (s1_value_ff <= s1_alpha_ff) begin
         new_flag = FLAG_UPPER;
      end else if (s1_value_ff >= s1_beta_ff) begin
         new_flag = FLAG_LOWER;
      end else begin
         new_flag = FLAG_EXACT;
      end
      wr_data                  = '0;
      wr_data.valid            = 1'b1;
      wr_data.tag              = s1_hash_ff;
      wr_data.info.depth       = s1_depth_ff;
      wr_data.info.score       = s1_value_ff;
      wr_data.info.flag        = new_flag;
      wr_data.info.move_stored = s1_mv_ff;
      wr_data.info.row         = s1_mv_ff ? s1_row_ff : '0;
      wr_data.info.col         = s1_mv_ff ? s1_col_ff : '0;
   end

   // memory write port: clearing pass or store write-back
   always_comb begin
      mem_we = clr_ff || s1_wr;
      mem_wa = clr_ff ? clr_idx_ff : s1_hash_ff[IDX_BITS-1:0];
      mem_wd = clr_ff ? slot_type'('0) : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         mem_rd_ff <= slot_mem[req_hash[IDX_BITS-1:0]];
      end
   end

   // clearing pass
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_BITS'(TABLE_SLOTS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // forward a write that lands while the next beat reads the same slot
   always_comb begin
      fwd_in = fwd_ff;
      if (req_accept) begin
         fwd_in = s1_wr && (req_hash[IDX_BITS-1:0] == s1_hash_ff[IDX_BITS-1:0]);
      end else if (s1_adv) begin
         fwd_in = 1'b0;
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // compare stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= op_type'(req_operation);
         s1_hash_ff  <= req_hash;
         s1_depth_ff <= req_remaining_depth;
         s1_alpha_ff <= req_alpha;
         s1_beta_ff  <= req_beta;
         s1_value_ff <= req_value;
         s1_mv_ff    <= req_move_valid;
         s1_row_ff   <= req_move_row;
         s1_col_ff   <= req_move_col;
         fwd_data_ff <= wr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (s1_op_ff == OP_PROBE) begin
            rsp_hit_ff      <= match;
            rsp_cutoff_ff   <= cut;
            rsp_cv_ff       <= cv;
            rsp_na_ff       <= na;
            rsp_nb_ff       <= nb;
            rsp_pv_valid_ff <= match && entry.info.move_stored;
            rsp_row_ff      <= (match && entry.info.move_stored) ? entry.info.row : '0;
            rsp_col_ff      <= (match && entry.info.move_stored) ? entry.info.col : '0;
            rsp_written_ff  <= 1'b0;
         end else begin
            rsp_hit_ff      <= 1'b0;
            rsp_cutoff_ff   <= 1'b0;
            rsp_cv_ff       <= '0;
            rsp_na_ff       <= '0;
            rsp_nb_ff       <= '0;
            rsp_pv_valid_ff <= 1'b0;
            rsp_row_ff      <= '0;
            rsp_col_ff      <= '0;
            rsp_written_ff  <= replace;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_cutoff       = rsp_cutoff_ff;
   assign rsp_cutoff_value = rsp_cv_ff;
   assign rsp_new_alpha    = rsp_na_ff;
   assign rsp_new_beta     = rsp_nb_ff;
   assign rsp_pv_valid     = rsp_pv_valid_ff;
   assign rsp_pv_row       = rsp_row_ff;
   assign rsp_pv_col       = rsp_col_ff;
   assign rsp_written      = rsp_written_ff;

   // checks
   `ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, clr_ff, !req_ready)
   `ASSERT_IMPLY(a_fwd_needs_item, clock, reset, fwd_ff, s1_valid_ff)
   `ASSERT_IMPLY(a_cut_hit, clock, reset, rsp_valid_ff && (rsp_cutoff_ff || rsp_pv_valid_ff), rsp_hit_ff)
   `ASSERT_NEVER(a_written_on_probe, clock, reset, rsp_valid_ff && rsp_written_ff && rsp_hit_ff)

endmodule

[verif/tb_transposition_table_probe_store.sv]
// self-checking testbench of the transposition table probe store
// depends on ttps_pkg and the transposition_table_probe_store top level
`timescale 1ns / 1ps

import ttps_pkg::*;

// one probe or store request as it crosses the req_ channel
typedef struct {
   op_type                       operation;
   logic [HASH_BITS-1:0]         hash;
   logic [DEPTH_BITS-1:0]        depth;
   logic signed [SCORE_BITS-1:0] alpha;
   logic signed [SCORE_BITS-1:0] beta;
   logic signed [SCORE_BITS-1:0] value;
   logic                         move_valid;
   logic [COORD_BITS-1:0]        row;
   logic [COORD_BITS-1:0]        col;
} tt_request_type;

// one reply as it crosses the rsp_ channel
typedef struct {
   logic                         hit;
   logic                         cutoff;
   logic signed [SCORE_BITS-1:0] cutoff_value;
   logic signed [SCORE_BITS-1:0] new_alpha;
   logic signed [SCORE_BITS-1:0] new_beta;
   logic                         pv_valid;
   logic [COORD_BITS-1:0]        pv_row;
   logic [COORD_BITS-1:0]        pv_col;
   logic                         written;
} tt_reply_type;

// shadow copy of the table plus the replies it predicts, oldest first
class tt_mirror_type;
   logic                 slot_valid [TABLE_SLOTS];
   logic [HASH_BITS-1:0] slot_tag [TABLE_SLOTS];
   info_type             slot_info [TABLE_SLOTS];
   tt_reply_type         expected_replies [$];
   int unsigned          mismatches;
   int unsigned          replies_seen;
   int unsigned          probes, stores, hits, cutoffs, writes;

   function new();
      foreach (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         slot_tag[i]   = '0;
         slot_info[i]  = '0;
      end
      mismatches   = 0;
      replies_seen = 0;
      probes = 0; stores = 0; hits = 0; cutoffs = 0; writes = 0;
   endfunction

   // compute the reply of one request and update the shadow table
   function tt_reply_type predict_reply(tt_request_type r);
      tt_reply_type                 rep;
      logic [IDX_BITS-1:0]          idx;
      logic                         match;
      info_type                     e;
      info_type                     w;
      logic signed [SCORE_BITS-1:0] es;
      logic signed [SCORE_BITS-1:0] na;
      logic signed [SCORE_BITS-1:0] nb;
      rep.hit = 1'b0;
      rep.cutoff = 1'b0;
      rep.cutoff_value = '0;
      rep.new_alpha = '0;
      rep.new_beta = '0;
      rep.pv_valid = 1'b0;
      rep.pv_row = '0;
      rep.pv_col = '0;
      rep.written = 1'b0;
      idx = r.hash[IDX_BITS-1:0];
      match = slot_valid[idx] && (slot_tag[idx] == r.hash);
      if (r.operation == OP_PROBE) begin
         probes++;
         na = r.alpha;
         nb = r.beta;
         if (match) begin
            e = slot_info[idx];
            es = e.score;
            rep.hit = 1'b1;
            hits++;
            if (e.move_stored) begin
               rep.pv_valid = 1'b1;
               rep.pv_row = e.row;
               rep.pv_col = e.col;
            end
            // deep enough entry: exact cuts, bounds tighten the window
            if (e.depth >= r.depth) begin
               if (e.flag == FLAG_EXACT) begin
                  rep.cutoff = 1'b1;
                  rep.cutoff_value = es;
               end else begin
                  if (e.flag == FLAG_LOWER && es > na)
                     na = es;
                  else if (e.flag == FLAG_UPPER && es < nb)
                     nb = es;
                  if (na >= nb) begin
                     rep.cutoff = 1'b1;
                     rep.cutoff_value = es;
                  end
               end
            end
         end
         if (rep.cutoff)
            cutoffs++;
         rep.new_alpha = na;
         rep.new_beta = nb;
      end else begin
         stores++;
         // replace on empty slot, other tag, or equal or deeper search
         if (!match || r.depth >= slot_info[idx].depth) begin
            w.depth = r.depth;
            w.score = r.value;
            if (r.value <= r.alpha)
               w.flag = FLAG_UPPER;
            else if (r.value >= r.beta)
               w.flag = FLAG_LOWER;
            else
               w.flag = FLAG_EXACT;
            w.move_stored = r.move_valid;
            w.row = r.move_valid ? r.row : '0;
            w.col = r.move_valid ? r.col : '0;
            slot_info[idx] = w;
            slot_tag[idx] = r.hash;
            slot_valid[idx] = 1'b1;
            rep.written = 1'b1;
            writes++;
         end
      end
      return rep;
   endfunction

   function void note_request(tt_request_type r);
      expected_replies.insert(expected_replies.size(), predict_reply(r));
   endfunction

   function int pending();
      return expected_replies.size();
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch at reply %0d, %s: got %h expected %h",
               replies_seen, what, got, want);
   endtask

   // compare one reply with the oldest prediction, field by field
   task check_reply(tt_reply_type got);
      tt_reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("unexpected reply", 64'd0, 64'd0);
      end else begin
         want = expected_replies.pop_front();
         if (got.hit !== want.hit)
            report_mismatch("hit", 64'(got.hit), 64'(want.hit));
         if (got.cutoff !== want.cutoff)
            report_mismatch("cutoff", 64'(got.cutoff), 64'(want.cutoff));
         if (got.cutoff_value !== want.cutoff_value)
            report_mismatch("cutoff_value", 64'(got.cutoff_value), 64'(want.cutoff_value));
         if (got.new_alpha !== want.new_alpha)
            report_mismatch("new_alpha", 64'(got.new_alpha), 64'(want.new_alpha));
         if (got.new_beta !== want.new_beta)
            report_mismatch("new_beta", 64'(got.new_beta), 64'(want.new_beta));
         if (got.pv_valid !== want.pv_valid)
            report_mismatch("pv_valid", 64'(got.pv_valid), 64'(want.pv_valid));
         if (got.pv_row !== want.pv_row)
            report_mismatch("pv_row", 64'(got.pv_row), 64'(want.pv_row));
         if (got.pv_col !== want.pv_col)
            report_mismatch("pv_col", 64'(got.pv_col), 64'(want.pv_col));
         if (got.written !== want.written)
            report_mismatch("written", 64'(got.written), 64'(want.written));
      end
      replies_seen++;
   endtask
endclass

module tb_transposition_table_probe_store;

   localparam int CLOCK_HALF  = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int POOL_KEYS   = 40;
   localparam int IDLE_PCT    = 13;

   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_operation = 1'b0;
   logic [HASH_BITS-1:0]         req_hash = '0;
   logic [DEPTH_BITS-1:0]        req_remaining_depth = '0;
   logic signed [SCORE_BITS-1:0] req_alpha = '0;
   logic signed [SCORE_BITS-1:0] req_beta = '0;
   logic signed [SCORE_BITS-1:0] req_value = '0;
   logic                         req_move_valid = 1'b0;
   logic [COORD_BITS-1:0]        req_move_row = '0;
   logic [COORD_BITS-1:0]        req_move_col = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_hit;
   logic                         rsp_cutoff;
   logic signed [SCORE_BITS-1:0] rsp_cutoff_value;
   logic signed [SCORE_BITS-1:0] rsp_new_alpha;
   logic signed [SCORE_BITS-1:0] rsp_new_beta;
   logic                         rsp_pv_valid;
   logic [COORD_BITS-1:0]        rsp_pv_row;
   logic [COORD_BITS-1:0]        rsp_pv_col;
   logic                         rsp_written;

   tt_mirror_type        sb = new();
   logic [HASH_BITS-1:0] key_pool [POOL_KEYS];
   bit                   sender_idle_on = 1'b0;
   bit                   rsp_idle_on = 1'b0;
   bit                   hold_now = 1'b0;
   bit                   hold_taken = 1'b0;
   int unsigned          hold_left = 0;
   int unsigned          cycle_count = 0;

   transposition_table_probe_store DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_hash            (req_hash),
      .req_remaining_depth (req_remaining_depth),
      .req_alpha           (req_alpha),
      .req_beta            (req_beta),
      .req_value           (req_value),
      .req_move_valid      (req_move_valid),
      .req_move_row        (req_move_row),
      .req_move_col        (req_move_col),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_cutoff          (rsp_cutoff),
      .rsp_cutoff_value    (rsp_cutoff_value),
      .rsp_new_alpha       (rsp_new_alpha),
      .rsp_new_beta        (rsp_new_beta),
      .rsp_pv_valid        (rsp_pv_valid),
      .rsp_pv_row          (rsp_pv_row),
      .rsp_pv_col          (rsp_pv_col),
      .rsp_written         (rsp_written)
   );

   // clock
   always #(CLOCK_HALF) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL transposition_table_probe_store");
         $finish;
      end
   end

   // reply side: check accepted beats, then choose the next ready level
   always @(posedge clock) begin
      tt_reply_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.hit = rsp_hit;
         got.cutoff = rsp_cutoff;
         got.cutoff_value = rsp_cutoff_value;
         got.new_alpha = rsp_new_alpha;
         got.new_beta = rsp_new_beta;
         got.pv_valid = rsp_pv_valid;
         got.pv_row = rsp_pv_row;
         got.pv_col = rsp_pv_col;
         got.written = rsp_written;
         sb.check_reply(got);
      end
      if (hold_now && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on) begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic tt_request_type make_beat(op_type op, logic [HASH_BITS-1:0] hash,
                                                int depth, logic signed [SCORE_BITS-1:0] alpha,
                                                logic signed [SCORE_BITS-1:0] beta,
                                                logic signed [SCORE_BITS-1:0] value,
                                                logic mv, int row, int col);
      tt_request_type r;
      r.operation = op;
      r.hash = hash;
      r.depth = depth[DEPTH_BITS-1:0];
      r.alpha = alpha;
      r.beta = beta;
      r.value = value;
      r.move_valid = mv;
      r.row = row[COORD_BITS-1:0];
      r.col = col[COORD_BITS-1:0];
      return r;
   endfunction

   // scores cluster near zero so that bounds interact, with extremes mixed in
   function automatic logic signed [SCORE_BITS-1:0] pick_score();
      logic signed [SCORE_BITS-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = SCORE_MIN;
               1: s = SCORE_MAX;
               2: s = -1;
               default: s = 0;
            endcase
         end
         1, 2: s = $urandom;
         default: s = int'($urandom_range(0, 40)) - 20;
      endcase
      return s;
   endfunction

   function automatic tt_request_type random_beat();
      tt_request_type r;
      r.operation = ($urandom_range(0, 99) < 55) ? OP_PROBE : OP_STORE;
      if ($urandom_range(0, 9) == 0)
         r.hash = {$urandom, $urandom};
      else
         r.hash = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      if ($urandom_range(0, 9) < 3)
         r.depth = DEPTH_BITS'($urandom_range(0, 3));
      else
         r.depth = DEPTH_BITS'($urandom_range(0, 63));
      r.alpha = pick_score();
      r.beta = pick_score();
      r.value = pick_score();
      r.move_valid = 1'($urandom_range(0, 1));
      r.row = COORD_BITS'($urandom_range(0, 31));
      r.col = COORD_BITS'($urandom_range(0, 31));
      return r;
   endfunction

   // offer one beat, hold it until accepted, then maybe leave a gap
   task send_beat(tt_request_type r);
      req_valid <= 1'b1;
      req_operation <= r.operation;
      req_hash <= r.hash;
      req_remaining_depth <= r.depth;
      req_alpha <= r.alpha;
      req_beta <= r.beta;
      req_value <= r.value;
      req_move_valid <= r.move_valid;
      req_move_row <= r.row;
      req_move_col <= r.col;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      if (sender_idle_on) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // mostly pool keys; a store is often followed by a probe of the same key
   task run_random(int count);
      tt_request_type r;
      tt_request_type last;
      bit             last_store;
      last_store = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (last_store && $urandom_range(0, 99) < 35) begin
            r = random_beat();
            r.operation = OP_PROBE;
            r.hash = last.hash;
            r.depth = DEPTH_BITS'($urandom_range(0, last.depth));
            r.alpha = last.value - int'($urandom_range(0, 10));
            r.beta = last.value + int'($urandom_range(0, 10));
         end else begin
            r = random_beat();
         end
         send_beat(r);
         last = r;
         last_store = (r.operation == OP_STORE);
      end
   endtask

   task stop_offering();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [HASH_BITS-1:0] k1, k2, k3, k4;
      logic [HASH_BITS-1:0] hi;

      // reset, then the block runs its clearing pass with req_ready low
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // key pool: the second half aliases the first half's slots with other tags
      for (int i = 0; i < POOL_KEYS; i++) begin
         hi = {$urandom, $urandom};
         if (i < POOL_KEYS / 2)
            key_pool[i] = hi;
         else
            key_pool[i] = {hi[HASH_BITS-1:IDX_BITS], key_pool[i - POOL_KEYS / 2][IDX_BITS-1:0]};
      end

      // directed part, back to back so stores forward into following probes
      k1 = {$urandom, $urandom};
      k2 = {~k1[HASH_BITS-1:IDX_BITS], k1[IDX_BITS-1:0]};
      k3 = '1;
      k4 = '0;
      // miss on an empty slot
      send_beat(make_beat(OP_PROBE, k1, 0, SCORE_MIN, SCORE_MAX, 0, 1'b0, 0, 0));
      // exact entry, then cutoff and a too-shallow probe
      send_beat(make_beat(OP_STORE, k1, 10, -10, 10, 5, 1'b1, 31, 31));
      send_beat(make_beat(OP_PROBE, k1, 10, -10, 10, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k1, 11, -10, 10, 0, 1'b0, 0, 0));
      // shallower store of the same key is refused
      send_beat(make_beat(OP_STORE, k1, 9, -10, 10, 7, 1'b0, 3, 3));
      send_beat(make_beat(OP_PROBE, k1, 9, -10, 10, 0, 1'b0, 0, 0));
      // other tag in the same slot replaces it; upper bound
      send_beat(make_beat(OP_STORE, k2, 0, -50, 50, -100, 1'b0, 7, 9));
      send_beat(make_beat(OP_PROBE, k1, 0, -10, 10, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k2, 0, -200, 200, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k2, 0, -100, 0, 0, 1'b0, 0, 0));
      // lower bound at full depth
      send_beat(make_beat(OP_STORE, k2, 63, -50, 50, 100, 1'b1, 0, 0));
      send_beat(make_beat(OP_PROBE, k2, 63, 0, 200, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k2, 63, 0, 100, 0, 1'b0, 0, 0));
      // window already closed: hit cuts off, miss does not
      send_beat(make_beat(OP_PROBE, k2, 63, 50, 10, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k1, 0, 5, -5, 0, 1'b0, 0, 0));
      // extreme keys and scores
      send_beat(make_beat(OP_STORE, k3, 63, SCORE_MIN, SCORE_MAX, SCORE_MAX, 1'b1, 31, 0));
      send_beat(make_beat(OP_STORE, k4, 0, SCORE_MIN, SCORE_MAX, SCORE_MIN, 1'b1, 0, 31));
      send_beat(make_beat(OP_PROBE, k3, 0, SCORE_MIN, SCORE_MAX, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k4, 0, SCORE_MIN, SCORE_MAX, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_PROBE, k4, 1, SCORE_MIN, SCORE_MAX, 0, 1'b0, 0, 0));
      // equal depth and same tag overwrites, a shallower store of k3 does not
      send_beat(make_beat(OP_STORE, k2, 63, -1, 1, 0, 1'b1, 17, 12));
      send_beat(make_beat(OP_PROBE, k2, 5, SCORE_MIN, SCORE_MAX, 0, 1'b0, 0, 0));
      send_beat(make_beat(OP_STORE, k3, 62, 0, 0, 0, 1'b0, 31, 31));
      send_beat(make_beat(OP_PROBE, k3, 63, -3, 3, 0, 1'b0, 0, 0));

      // random part with idling on both sides
      sender_idle_on = 1'b1;
      stop_offering();
      rsp_idle_on <= 1'b1;
      run_random(250);

      // long receiver hold while the sender keeps offering
      hold_now <= 1'b1;
      run_random(100);

      // stretch with no idling at all
      sender_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      run_random(200);

      // sender pauses until every reply is in
      stop_offering();
      wait_drained();
      sender_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      run_random(300);

      // drain and let the pipeline settle
      stop_offering();
      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d probes (%0d hits, %0d cutoffs) and %0d stores (%0d slot writes)",
               sb.probes, sb.hits, sb.cutoffs, sb.stores, sb.writes);
      $display("%0d replies checked, %0d mismatches, %0d left waiting",
               sb.replies_seen, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS transposition_table_probe_store");
      end else begin
         $display("FAIL transposition_table_probe_store");
      end
      $finish;
   end

endmodule
